// File: design/swt_pkg.sv
`default_nettype none
package swt_pkg;

	localparam int NUM_TIMERS_DEF = 32;
	localparam int MODE_W         = 2;
	localparam int TIMER_ID_W     = 5;
	localparam int DEADLINE_W     = 32;
	localparam int PAYLOAD_W      = 8;
	localparam int CMD_DEPTH      = 2;
	localparam int RES_DEPTH      = 4;

	localparam logic [DEADLINE_W-1:0] NO_DEADLINE = '1;

	// input mode codes
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ARM    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_ARM,
		OP_CANCEL
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [TIMER_ID_W-1:0] id;
		logic [DEADLINE_W-1:0] deadline;
		logic [PAYLOAD_W-1:0]  payload;
	} cmd_t;

	typedef struct packed {
		logic [TIMER_ID_W-1:0] id;
		logic [PAYLOAD_W-1:0]  payload;
		logic                  last;
	} res_t;

endpackage
`default_nettype wire

// File: design/swt_front.sv
`default_nettype none
module swt_front #(
	parameter int NUM_TIMERS = swt_pkg::NUM_TIMERS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output      logic                            full,
	input  wire logic [swt_pkg::MODE_W-1:0]      mode,
	input  wire logic [swt_pkg::TIMER_ID_W-1:0]  timer_id,
	input  wire logic [swt_pkg::DEADLINE_W-1:0]  deadline,
	input  wire logic [swt_pkg::PAYLOAD_W-1:0]   payload,
	input  wire logic                            cmd_pop,
	output      logic                            cmd_empty,
	output      swt_pkg::cmd_t                   cmd
);
	import swt_pkg::*;

	localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CW = $clog2(CMD_DEPTH + 1);

	cmd_t            fifo_q [CMD_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	cmd_t            dec;
	logic            keep;
	logic            wr;
	logic            rd;
	logic            id_ok;

	// classify: mode 3, and arm or cancel with an out-of-range id, are dropped here
	always_comb begin
		id_ok       = (int'(timer_id) < NUM_TIMERS);
		dec.id       = timer_id;
		dec.deadline = deadline;
		dec.payload  = payload;
		dec.op       = OP_TICK;
		keep         = 1'b0;
		unique case (mode)
			MODE_TICK: begin
				keep = 1'b1;
			end
			MODE_ARM: begin
				dec.op = OP_ARM;
				keep   = id_ok;
			end
			MODE_CANCEL: begin
				dec.op = OP_CANCEL;
				keep   = id_ok;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full      = (count_q == CW'(CMD_DEPTH));
	assign cmd_empty = (count_q == '0);
	assign wr        = push && !full && keep;
	assign rd        = cmd_pop && !cmd_empty;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/swt_res_fifo.sv
`default_nettype none
module swt_res_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           res_push,
	input  wire swt_pkg::res_t  res_in,
	output      logic           res_full,
	input  wire logic           pop,
	output      logic           empty,
	output      swt_pkg::res_t  res_out
);
	import swt_pkg::*;

	localparam int PW = $clog2(RES_DEPTH);
	localparam int CW = $clog2(RES_DEPTH + 1);

	res_t          fifo_q [RES_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          wr;
	logic          rd;

	assign res_full = (count_q == CW'(RES_DEPTH));
	assign empty    = (count_q == '0);
	assign wr       = res_push && !res_full;
	assign rd       = pop && !empty;
	assign res_out  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			fifo_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/swt_back.sv
`default_nettype none
module swt_back #(
	parameter int NUM_TIMERS = swt_pkg::NUM_TIMERS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_empty,
	input  wire swt_pkg::cmd_t  cmd,
	output      logic           cmd_pop,
	input  wire logic           res_full,
	output      logic           res_push,
	output      swt_pkg::res_t  res
);
	import swt_pkg::*;

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t                 state_q;
	logic [DEADLINE_W-1:0]  tick_q;
	logic [DEADLINE_W-1:0]  next_dl_q;
	logic [DEADLINE_W-1:0]  min_q;
	logic [NUM_TIMERS-1:0]  active_q;
	logic [CW-1:0]          rd_cnt_q;
	logic                   v_s1;
	logic [IW-1:0]          idx_s1;
	logic                   pend_v_q;
	logic [TIMER_ID_W-1:0]  pend_id_q;
	logic [PAYLOAD_W-1:0]   pend_pl_q;

	logic [DEADLINE_W-1:0]  dl_mem [NUM_TIMERS];
	logic [PAYLOAD_W-1:0]   pl_mem [NUM_TIMERS];
	logic [DEADLINE_W-1:0]  rd_dl_s1;
	logic [PAYLOAD_W-1:0]   rd_pl_s1;

	logic [IW-1:0]          cmd_idx;
	logic [DEADLINE_W-1:0]  tick_nxt;
	logic                   issue;
	logic                   fire;
	logic                   stall;
	logic                   adv;
	logic                   rd_en;
	logic                   mem_wr;

	assign cmd_idx  = IW'(cmd.id);
	assign tick_nxt = tick_q + 1'b1;
	assign cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;
	assign mem_wr   = cmd_pop && (cmd.op == OP_ARM);

	// scan pipe: read issue, then compare on the registered read data
	assign issue = (state_q == ST_SCAN) && (rd_cnt_q < CW'(NUM_TIMERS));
	assign fire  = v_s1 && active_q[idx_s1] && (rd_dl_s1 <= tick_q);
	// holding back one fired timer so the final one can carry last
	assign stall = fire && pend_v_q && res_full;
	assign adv   = !stall;
	assign rd_en = issue && adv;

	always_comb begin
		res_push    = 1'b0;
		res.id      = pend_id_q;
		res.payload = pend_pl_q;
		res.last    = (state_q == ST_FLUSH);
		if (state_q == ST_SCAN) begin
			res_push = fire && pend_v_q && !res_full;
		end else if (state_q == ST_FLUSH) begin
			res_push = pend_v_q && !res_full;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			dl_mem[cmd_idx] <= cmd.deadline;
			pl_mem[cmd_idx] <= cmd.payload;
		end
		if (rd_en) begin
			rd_dl_s1 <= dl_mem[rd_cnt_q[IW-1:0]];
			rd_pl_s1 <= pl_mem[rd_cnt_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tick_q    <= '0;
			next_dl_q <= NO_DEADLINE;
			min_q     <= NO_DEADLINE;
			active_q  <= '0;
			rd_cnt_q  <= '0;
			v_s1      <= 1'b0;
			idx_s1    <= '0;
			pend_v_q  <= 1'b0;
			pend_id_q <= '0;
			pend_pl_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd.op)
							OP_TICK: begin
								tick_q <= tick_nxt;
								if (next_dl_q <= tick_nxt) begin
									state_q  <= ST_SCAN;
									rd_cnt_q <= '0;
									v_s1     <= 1'b0;
									min_q    <= NO_DEADLINE;
									pend_v_q <= 1'b0;
								end
							end
							OP_ARM: begin
								active_q[cmd_idx] <= 1'b1;
								if (cmd.deadline < next_dl_q) begin
									next_dl_q <= cmd.deadline;
								end
							end
							OP_CANCEL: begin
								active_q[cmd_idx] <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (adv) begin
						v_s1   <= issue;
						idx_s1 <= rd_cnt_q[IW-1:0];
						if (issue) begin
							rd_cnt_q <= rd_cnt_q + 1'b1;
						end
						if (v_s1) begin
							if (fire) begin
								active_q[idx_s1] <= 1'b0;
								pend_v_q         <= 1'b1;
								pend_id_q        <= TIMER_ID_W'(idx_s1);
								pend_pl_q        <= rd_pl_s1;
							end else if (active_q[idx_s1] && (rd_dl_s1 < min_q)) begin
								min_q <= rd_dl_s1;
							end
						end
						if (!v_s1 && !issue) begin
							next_dl_q <= min_q;
							state_q   <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (!res_full) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: design/software_timer_expiry_scan.sv
// Software timer table with expiry scan.
// Input side is a queue: present mode/timer_id/deadline/payload with push;
// a beat is taken when push is high and full is low. Mode 0 is a tick, 1 arms
// a timer (absolute deadline plus payload byte), 2 cancels one; mode 3 and
// arm or cancel with an out-of-range id are dropped at the front.
// Result side is a queue: while empty is low, fired_timer/fired_payload/last
// show the oldest expiry; pop with empty low takes the beat. last marks the
// final expiry of one tick.
// Arm, cancel and a tick that finds nothing due retire in the idle state
// of the back end. A tick that is due scans the whole table through the
// single read port of the deadline/payload memory, and the scan holds
// while the result queue stays full.
// A two-entry command queue decouples intake from the scan, so items keep
// flowing in while a scan runs until that queue fills.
// Reset clears the tick count, the active bits and both queues and sets the
// earliest deadline to all ones; the memories are not cleared.
// If the receiver stalls, the result queue fills, the scan holds in place and
// then the command queue backs up into full.
`default_nettype none
module software_timer_expiry_scan #(
	parameter int NUM_TIMERS = swt_pkg::NUM_TIMERS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output      logic                            full,
	input  wire logic [swt_pkg::MODE_W-1:0]      mode,
	input  wire logic [swt_pkg::TIMER_ID_W-1:0]  timer_id,
	input  wire logic [swt_pkg::DEADLINE_W-1:0]  deadline,
	input  wire logic [swt_pkg::PAYLOAD_W-1:0]   payload,
	output      logic                            empty,
	input  wire logic                            pop,
	output      logic [swt_pkg::TIMER_ID_W-1:0]  fired_timer,
	output      logic [swt_pkg::PAYLOAD_W-1:0]   fired_payload,
	output      logic                            last
);
	import swt_pkg::*;

	cmd_t cmd;
	logic cmd_empty;
	logic cmd_pop;
	res_t res_in;
	res_t res_out;
	logic res_push;
	logic res_full;

	// front: classify and queue commands
	swt_front #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.timer_id  (timer_id),
		.deadline  (deadline),
		.payload   (payload),
		.cmd_pop   (cmd_pop),
		.cmd_empty (cmd_empty),
		.cmd       (cmd)
	);

	// back: timer state, memories and the expiry scan
	swt_back #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// result queue decouples the scan from the receiver
	swt_res_fifo u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.res_out  (res_out)
	);

	assign fired_timer   = res_out.id;
	assign fired_payload = res_out.payload;
	assign last          = res_out.last;

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps

// Expiry scoreboard: mirrors the timer table and queues the expiries that each
// accepted tick should produce, then checks popped beats against that queue.
class expiry_scoreboard;
	logic [swt_pkg::DEADLINE_W-1:0] tick_cnt;
	logic [swt_pkg::DEADLINE_W-1:0] earliest;
	bit                             armed   [swt_pkg::NUM_TIMERS_DEF];
	logic [swt_pkg::DEADLINE_W-1:0] due_at  [swt_pkg::NUM_TIMERS_DEF];
	logic [swt_pkg::PAYLOAD_W-1:0]  byte_of [swt_pkg::NUM_TIMERS_DEF];
	swt_pkg::res_t                  pending_expiries [$];
	int                             mismatches;

	function new();
		tick_cnt   = '0;
		earliest   = swt_pkg::NO_DEADLINE;
		mismatches = 0;
		foreach (armed[k]) armed[k] = 1'b0;
	endfunction

	function int pending();
		return pending_expiries.size();
	endfunction

	task report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Update the mirrored table for one accepted command beat.
	function void note_command(
		input logic [swt_pkg::MODE_W-1:0]     m,
		input logic [swt_pkg::TIMER_ID_W-1:0] id,
		input logic [swt_pkg::DEADLINE_W-1:0] dl,
		input logic [swt_pkg::PAYLOAD_W-1:0]  pl
	);
		int            fired;
		swt_pkg::res_t hit;
		fired = 0;
		if (m == swt_pkg::MODE_TICK) begin
			tick_cnt++;
			if (earliest > tick_cnt)
				return;
			earliest = swt_pkg::NO_DEADLINE;
			for (int k = 0; k < swt_pkg::NUM_TIMERS_DEF; k++) begin
				if (!armed[k])
					continue;
				if (due_at[k] <= tick_cnt) begin
					armed[k]    = 1'b0;
					hit.id      = 5'(k);
					hit.payload = byte_of[k];
					hit.last    = 1'b0;
					pending_expiries.push_back(hit);
					fired++;
				end else if (due_at[k] < earliest) begin
					earliest = due_at[k];
				end
			end
			if (fired > 0) begin
				hit      = pending_expiries.pop_back();
				hit.last = 1'b1;
				pending_expiries.push_back(hit);
			end
		end else if (int'(id) < swt_pkg::NUM_TIMERS_DEF) begin
			if (m == swt_pkg::MODE_ARM) begin
				armed[id]   = 1'b1;
				due_at[id]  = dl;
				byte_of[id] = pl;
				if (dl < earliest)
					earliest = dl;
			end else if (m == swt_pkg::MODE_CANCEL) begin
				armed[id] = 1'b0;
			end
		end
	endfunction

	task check_expiry(
		input logic [swt_pkg::TIMER_ID_W-1:0] t,
		input logic [swt_pkg::PAYLOAD_W-1:0]  p,
		input logic                           l
	);
		swt_pkg::res_t want;
		if (pending_expiries.size() == 0) begin
			report_mismatch($sformatf("unexpected expiry: timer %0d payload 0x%02h last %0b",
				t, p, l));
			return;
		end
		want = pending_expiries.pop_front();
		if (t !== want.id)
			report_mismatch($sformatf("fired_timer %0d, want %0d", t, want.id));
		if (p !== want.payload)
			report_mismatch($sformatf("fired_payload 0x%02h, want 0x%02h (timer %0d)",
				p, want.payload, want.id));
		if (l !== want.last)
			report_mismatch($sformatf("last %0b, want %0b (timer %0d)", l, want.last, want.id));
	endtask
endclass

module tb_top;

	localparam int NUM_TIMERS  = swt_pkg::NUM_TIMERS_DEF;
	localparam int PHASE_BEATS = 85;
	// mode 3 has no name in the package; the block must drop it
	localparam logic [swt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	// watchdog: worst case is a full 32-expiry scan per tick behind a
	// heavily stalled receiver, taken several times over
	localparam int CYCLE_LIMIT = 1_000_000;
	// a due tick holds the back end for its scan; allow for the one in
	// progress and two more queued behind it, plus margin
	localparam int SETTLE_CYCLES = 3 * (NUM_TIMERS + 4) + 20;

	logic                             clk;
	logic                             arst_n;
	logic                             push;
	logic                             full;
	logic [swt_pkg::MODE_W-1:0]       mode;
	logic [swt_pkg::TIMER_ID_W-1:0]   timer_id;
	logic [swt_pkg::DEADLINE_W-1:0]   deadline;
	logic [swt_pkg::PAYLOAD_W-1:0]    payload;
	logic                             empty;
	logic                             pop;
	logic [swt_pkg::TIMER_ID_W-1:0]   fired_timer;
	logic [swt_pkg::PAYLOAD_W-1:0]    fired_payload;
	logic                             last;

	expiry_scoreboard sb;
	int               send_idle;   // percent of cycles the sender holds off
	int               recv_stall;  // percent of cycles the receiver holds off
	int               cycle_count;

	software_timer_expiry_scan #(
		.NUM_TIMERS(NUM_TIMERS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.timer_id     (timer_id),
		.deadline     (deadline),
		.payload      (payload),
		.empty        (empty),
		.pop          (pop),
		.fired_timer  (fired_timer),
		.fired_payload(fired_payload),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: pop is redrawn once per falling edge, so it stays stable
	// across the rising edge where the beat is taken.
	always @(negedge clk) begin
		pop <= (32'($urandom_range(99)) >= 32'(recv_stall));
	end

	// Sampling at the rising edge: both handshakes see pre-edge values, the
	// block's own updates land in the NBA region after this.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else if (arst_n) begin
			if (push && !full)
				sb.note_command(mode, timer_id, deadline, payload);
			if (pop && !empty)
				sb.check_expiry(fired_timer, fired_payload, last);
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat
	// was taken, so the scoreboard already holds the updated tick count.
	task automatic send_command(
		input logic [swt_pkg::MODE_W-1:0]     m,
		input logic [swt_pkg::TIMER_ID_W-1:0] id,
		input logic [swt_pkg::DEADLINE_W-1:0] dl,
		input logic [swt_pkg::PAYLOAD_W-1:0]  pl
	);
		while (32'($urandom_range(99)) < 32'(send_idle)) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push     <= 1'b1;
		mode     <= m;
		timer_id <= id;
		deadline <= dl;
		payload  <= pl;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
	endtask

	// id, deadline and payload are don't-care on a tick: feed noise
	task automatic send_tick();
		send_command(swt_pkg::MODE_TICK, 5'($urandom), 32'($urandom), 8'($urandom));
	endtask

	task automatic arm_timer(
		input logic [swt_pkg::TIMER_ID_W-1:0] id,
		input logic [swt_pkg::DEADLINE_W-1:0] dl,
		input logic [swt_pkg::PAYLOAD_W-1:0]  pl
	);
		send_command(swt_pkg::MODE_ARM, id, dl, pl);
	endtask

	task automatic cancel_timer(input logic [swt_pkg::TIMER_ID_W-1:0] id);
		send_command(swt_pkg::MODE_CANCEL, id, 32'($urandom), 8'($urandom));
	endtask

	// Arm cnt consecutive ids (wrapping) with one shared near deadline so
	// that a single tick fires them together.
	task automatic arm_burst(input int cnt, input logic [swt_pkg::DEADLINE_W-1:0] dl);
		int base;
		base = $urandom_range(NUM_TIMERS - 1);
		for (int i = 0; i < cnt; i++)
			arm_timer(5'((base + i) % NUM_TIMERS), dl, 8'($urandom));
	endtask

	// Mostly well-formed traffic: arms just ahead of the tick count and
	// ticks to reach them, with cancels, far deadlines and dropped modes mixed in.
	task automatic run_random(input int beats);
		int                             done;
		int                             r;
		int                             cnt;
		logic [swt_pkg::DEADLINE_W-1:0] dl;
		done = 0;
		while (done < beats) begin
			r = $urandom_range(99);
			if (r < 3) begin
				cnt = $urandom_range(2, NUM_TIMERS);
				arm_burst(cnt, sb.tick_cnt + 32'($urandom_range(0, 2)));
				done += cnt;
			end else if (r < 50) begin
				send_tick();
				done++;
			end else if (r < 78) begin
				// near deadline; one in four is already behind the count
				if ($urandom_range(3) == 0)
					dl = sb.tick_cnt - 32'($urandom_range(1, 3));
				else
					dl = sb.tick_cnt + 32'($urandom_range(0, 12));
				arm_timer(5'($urandom), dl, 8'($urandom));
				done++;
			end else if (r < 84) begin
				case ($urandom_range(2))
					0: dl = '0;
					1: dl = swt_pkg::NO_DEADLINE;
					default: dl = 32'($urandom);
				endcase
				arm_timer(5'($urandom), dl, 8'($urandom));
				done++;
			end else if (r < 95) begin
				cancel_timer(5'($urandom));
				done++;
			end else begin
				// dropped by the block, not counted
				send_command(MODE_UNUSED, 5'($urandom), 32'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		sb          = new();
		cycle_count = 0;
		send_idle   = 0;
		recv_stall  = 0;
		arst_n      = 1'b0;
		push        = 1'b0;
		pop         = 1'b0;
		mode        = swt_pkg::MODE_TICK;
		timer_id    = '0;
		deadline    = '0;
		payload     = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed ---
		// tick on an empty table: earliest is all ones, nothing scans
		send_command(swt_pkg::MODE_TICK, '1, '1, '1);
		// deadline already passed at arm: fires on the next tick
		arm_timer(5'd0, '0, 8'hff);
		arm_timer(5'd31, sb.tick_cnt + 32'd2, 8'h00);
		// mode 3 must leave no trace
		send_command(MODE_UNUSED, '1, '1, '1);
		send_tick();                                    // timer 0 only, last set
		// re-arm: earliest stays at the lower value
		arm_timer(5'd5, sb.tick_cnt + 32'd1, 8'ha5);
		arm_timer(5'd5, sb.tick_cnt + 32'd5, 8'h5a);
		arm_timer(5'd7, swt_pkg::NO_DEADLINE, 8'h3c);   // never due
		// cancel leaves the cached earliest stale
		cancel_timer(5'd31);
		send_tick();                                    // scans, fires nothing
		arm_timer(5'd20, sb.tick_cnt + 32'd1, 8'h18);
		arm_timer(5'd12, sb.tick_cnt + 32'd1, 8'h81);
		arm_timer(5'd3,  sb.tick_cnt + 32'd1, 8'h7e);
		send_tick();                                    // 3, 12, 20 in index order
		repeat (3) send_tick();                         // timer 5 with re-armed payload
		cancel_timer(5'd7);
		send_tick();

		// --- random: full table expiring on one tick first ---
		arm_burst(NUM_TIMERS, sb.tick_cnt);
		send_tick();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 73; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 73; end
				default: begin send_idle = 18; recv_stall = 18; end
			endcase
			run_random(PHASE_BEATS);
		end
		push       <= 1'b0;
		recv_stall = 0;

		// drain, then let any in-flight scan finish
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: software_timer_expiry_scan.f
design/swt_pkg.sv
design/swt_front.sv
design/swt_res_fifo.sv
design/swt_back.sv
design/software_timer_expiry_scan.sv
test/tb_top.sv
